// ----- rtl/rpfp_pkg.sv -----
`timescale 1ns / 1ps

package rpfp_pkg;

   // Request types.
   localparam logic [1:0] REQ_ADVANCE   = 2'd0;
   localparam logic [1:0] REQ_FOCUS     = 2'd1;
   localparam logic [1:0] REQ_TERMINATE = 2'd2;

   // Event kinds carried on the result channel.
   localparam logic [2:0] KIND_RETRACE    = 3'd0;
   localparam logic [2:0] KIND_LOST       = 3'd1;
   localparam logic [2:0] KIND_GAINED     = 3'd2;
   localparam logic [2:0] KIND_TERM_REQ   = 3'd3;
   localparam logic [2:0] KIND_TERMINATED = 3'd4;
   localparam logic [2:0] KIND_CLOSE      = 3'd5;

   // Closing status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_REVERSED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   localparam int unsigned DEFAULT_EVENT_BUDGET = 32;

   localparam int unsigned TIME_W  = 64;
   localparam int unsigned COUNT_W = 6;
   // The offset of deadline 64, the furthest ever computed, is just under 2^30.
   localparam int unsigned OFFSET_W = 31;
   localparam int unsigned REM_W    = 6;

   localparam logic [63:0] NS_PER_S  = 64'd1_000_000_000;
   localparam logic [63:0] VI_RATE   = 64'd60;
   localparam logic [63:0] FRAME_NS  = NS_PER_S / VI_RATE;
   localparam logic [63:0] FRAME_REM = NS_PER_S % VI_RATE;

   typedef struct packed {
      logic       latch_req;
      logic       take_time;
      logic       set_status;
      logic [1:0] status_code;
      logic       apply_focus;
      logic       set_terminating;
      logic       set_terminated;
      logic       push;
      logic [2:0] push_kind;
      logic       reanchor;
      logic       load_deadline;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       want;
      logic       reversed;
      logic       pacing;
      logic       active;
      logic       focus_differs;
      logic       budget_left;
      logic       due;
      logic       slot_free;
      logic       sum_carry;
   } sts_type;

endpackage

// ----- rtl/rpfp_ctrl.sv -----
`timescale 1ns / 1ps

module rpfp_ctrl import rpfp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_DECIDE    = 9'b000000010,
      ST_LOOP      = 9'b000000100,
      ST_RETRACE   = 9'b000001000,
      ST_DEADLINE  = 9'b000010000,
      ST_FOCUS_EV  = 9'b000100000,
      ST_TERM_REQ  = 9'b001000000,
      ST_TERM_DONE = 9'b010000000,
      ST_CLOSE     = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.req_type != REQ_ADVANCE && sts.req_type != REQ_FOCUS &&
                sts.req_type != REQ_TERMINATE) begin
               state_in = ST_CLOSE;
            end else if (sts.reversed) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_REVERSED;
               state_in        = ST_CLOSE;
            end else begin
               cmd.take_time = 1'b1;
               state_in      = ST_CLOSE;
               case (sts.req_type)
                  REQ_ADVANCE: begin
                     if (sts.pacing) begin
                        state_in = ST_LOOP;
                     end
                  end
                  REQ_FOCUS: begin
                     if (sts.active && sts.focus_differs) begin
                        cmd.apply_focus = 1'b1;
                        if (sts.budget_left) begin
                           state_in = ST_FOCUS_EV;
                        end else begin
                           cmd.set_status  = 1'b1;
                           cmd.status_code = STATUS_FULL;
                        end
                     end
                  end
                  REQ_TERMINATE: begin
                     if (sts.active) begin
                        cmd.set_terminating = 1'b1;
                        if (sts.budget_left) begin
                           state_in = ST_TERM_REQ;
                        end else begin
                           cmd.set_status  = 1'b1;
                           cmd.status_code = STATUS_FULL;
                        end
                     end
                  end
                  default: state_in = ST_CLOSE;
               endcase
            end
         end
         ST_LOOP: begin
            if (!sts.due) begin
               state_in = ST_CLOSE;
            end else if (!sts.budget_left) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_FULL;
               state_in        = ST_CLOSE;
            end else begin
               state_in = ST_RETRACE;
            end
         end
         ST_RETRACE: begin
            if (sts.slot_free) begin
               cmd.push      = 1'b1;
               cmd.push_kind = KIND_RETRACE;
               state_in      = ST_DEADLINE;
            end
         end
         ST_DEADLINE: begin
            cmd.load_deadline = 1'b1;
            if (sts.sum_carry) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_OVERFLOW;
               state_in        = ST_CLOSE;
            end else if (sts.req_type == REQ_ADVANCE) begin
               state_in = ST_LOOP;
            end else begin
               state_in = ST_CLOSE;
            end
         end
         ST_FOCUS_EV: begin
            if (sts.slot_free) begin
               cmd.push = 1'b1;
               if (sts.want) begin
                  cmd.push_kind = KIND_GAINED;
                  cmd.reanchor  = 1'b1;
                  state_in      = ST_DEADLINE;
               end else begin
                  cmd.push_kind = KIND_LOST;
                  state_in      = ST_CLOSE;
               end
            end
         end
         ST_TERM_REQ: begin
            if (sts.slot_free) begin
               cmd.push           = 1'b1;
               cmd.push_kind      = KIND_TERM_REQ;
               cmd.set_terminated = 1'b1;
               state_in           = ST_TERM_DONE;
            end
         end
         ST_TERM_DONE: begin
            if (!sts.budget_left) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_FULL;
               state_in        = ST_CLOSE;
            end else if (sts.slot_free) begin
               cmd.push      = 1'b1;
               cmd.push_kind = KIND_TERMINATED;
               state_in      = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            if (sts.slot_free) begin
               cmd.push      = 1'b1;
               cmd.push_kind = KIND_CLOSE;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/rpfp_datapath.sv -----
`timescale 1ns / 1ps

module rpfp_datapath import rpfp_pkg::*; #(
   parameter int unsigned EVENT_BUDGET = DEFAULT_EVENT_BUDGET
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_type,
   input  logic [TIME_W-1:0]   req_now_time,
   input  logic                req_focus_value,
   input  cmd_type             cmd,
   output sts_type             sts,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_event_kind,
   output logic [TIME_W-1:0]   rsp_event_time,
   output logic                rsp_has_frame,
   output logic [COUNT_W-1:0]  rsp_frame_number,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);

   localparam logic [COUNT_W-1:0]  BUDGET      = COUNT_W'(EVENT_BUDGET);
   localparam logic [OFFSET_W-1:0] PERIOD      = OFFSET_W'(FRAME_NS);
   localparam logic [REM_W:0]      PERIOD_REM  = (REM_W + 1)'(FRAME_REM);
   localparam logic [REM_W:0]      RATE        = (REM_W + 1)'(VI_RATE);

   // Latched request.
   logic [1:0]          type_ff;
   logic [TIME_W-1:0]   now_ff;
   logic                want_ff;
   logic [1:0]          status_ff;
   logic [1:0]          status_in;

   // Pacer state.
   logic [TIME_W-1:0]   current_ff, current_in;
   logic [TIME_W-1:0]   anchor_ff, anchor_in;
   logic [TIME_W-1:0]   deadline_ff, deadline_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [COUNT_W-1:0]  frame_ff, frame_in;
   logic [COUNT_W-1:0]  events_ff, events_in;
   logic                focused_ff, focused_in;
   logic                terminating_ff, terminating_in;
   logic                terminated_ff, terminated_in;

   // Output word.
   logic                out_valid_ff, out_valid_in;
   logic [2:0]          out_kind_ff;
   logic [TIME_W-1:0]   out_time_ff;
   logic                out_has_frame_ff;
   logic [COUNT_W-1:0]  out_frame_ff;
   logic [1:0]          out_status_ff;
   logic                out_last_ff;

   logic [TIME_W:0]     deadline_sum;
   logic [REM_W:0]      rem_sum;
   logic                rem_wrap;
   logic                is_retrace;
   logic                is_close;

   assign deadline_sum = {1'b0, anchor_ff} + (TIME_W + 1)'(offset_ff);
   // The fractional part of 1e9/60 is carried in sixtieths, so every offset
   // is the exact floor of n * 1e9 / 60.
   assign rem_sum  = {1'b0, rem_ff} + PERIOD_REM;
   assign rem_wrap = (rem_sum >= RATE);

   assign is_retrace = cmd.push && (cmd.push_kind == KIND_RETRACE);
   assign is_close   = cmd.push && (cmd.push_kind == KIND_CLOSE);

   always_comb begin
      sts.req_type      = type_ff;
      sts.want          = want_ff;
      sts.reversed      = (now_ff < current_ff);
      sts.active        = !terminating_ff && !terminated_ff;
      sts.pacing        = focused_ff && !terminating_ff && !terminated_ff;
      sts.focus_differs = (focused_ff != want_ff);
      sts.budget_left   = (events_ff < BUDGET);
      sts.due           = (deadline_ff <= current_ff);
      sts.slot_free     = !out_valid_ff || rsp_ready;
      sts.sum_carry     = deadline_sum[TIME_W];
   end

   always_comb begin
      status_in      = status_ff;
      current_in     = current_ff;
      anchor_in      = anchor_ff;
      deadline_in    = deadline_ff;
      offset_in      = offset_ff;
      rem_in         = rem_ff;
      frame_in       = frame_ff;
      events_in      = events_ff;
      focused_in     = focused_ff;
      terminating_in = terminating_ff;
      terminated_in  = terminated_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;

      if (cmd.latch_req) begin
         status_in = STATUS_OK;
      end else if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
      if (cmd.take_time) begin
         current_in = now_ff;
      end
      if (cmd.apply_focus) begin
         focused_in = want_ff;
      end
      if (cmd.set_terminating) begin
         terminating_in = 1'b1;
      end
      if (cmd.set_terminated) begin
         terminated_in = 1'b1;
      end
      if (cmd.push) begin
         out_valid_in = 1'b1;
         if (!is_close) begin
            events_in = events_ff + COUNT_W'(1);
         end
      end
      if (is_retrace) begin
         frame_in  = frame_ff + COUNT_W'(1);
         offset_in = offset_ff + PERIOD + OFFSET_W'(rem_wrap);
         rem_in    = rem_wrap ? REM_W'(rem_sum - RATE) : rem_sum[REM_W-1:0];
      end
      if (cmd.reanchor) begin
         anchor_in = now_ff;
         offset_in = PERIOD;
         rem_in    = PERIOD_REM[REM_W-1:0];
      end
      if (cmd.load_deadline) begin
         deadline_in = deadline_sum[TIME_W] ? {TIME_W{1'b1}} : deadline_sum[TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff      <= STATUS_OK;
         current_ff     <= '0;
         anchor_ff      <= '0;
         deadline_ff    <= TIME_W'(FRAME_NS);
         offset_ff      <= PERIOD;
         rem_ff         <= PERIOD_REM[REM_W-1:0];
         frame_ff       <= '0;
         events_ff      <= '0;
         focused_ff     <= 1'b1;
         terminating_ff <= 1'b0;
         terminated_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         status_ff      <= status_in;
         current_ff     <= current_in;
         anchor_ff      <= anchor_in;
         deadline_ff    <= deadline_in;
         offset_ff      <= offset_in;
         rem_ff         <= rem_in;
         frame_ff       <= frame_in;
         events_ff      <= events_in;
         focused_ff     <= focused_in;
         terminating_ff <= terminating_in;
         terminated_ff  <= terminated_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         type_ff <= req_type;
         now_ff  <= req_now_time;
         want_ff <= req_focus_value;
      end
      if (cmd.push) begin
         out_kind_ff      <= cmd.push_kind;
         out_time_ff      <= is_retrace ? deadline_ff : now_ff;
         out_has_frame_ff <= is_retrace;
         out_frame_ff     <= is_retrace ? frame_ff : '0;
         out_status_ff    <= is_close ? status_ff : STATUS_OK;
         out_last_ff      <= is_close;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_kind   = out_kind_ff;
   assign rsp_event_time   = out_time_ff;
   assign rsp_has_frame    = out_has_frame_ff;
   assign rsp_frame_number = out_frame_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_last         = out_last_ff;

endmodule

// ----- rtl/retrace_pacer_with_focus_pause_top.sv -----
`timescale 1ns / 1ps

// Retrace pacer with focus pause.
// Requests arrive on the req_ channel (valid/ready): advance time, set focus
// or request termination, each with a nanosecond timestamp. Every request
// produces zero or more event words on the rsp_ channel followed by one
// closing word with rsp_last high and the request's status.
// One request is handled at a time; req_ready is high only while the
// controller is idle. A request with no events goes from the decide step
// straight to its closing word, through a deadline check first for an
// advance that is pacing. Each retrace steps through the deadline compare,
// the emit and the next deadline add, and each focus or termination event
// through its own push states; the next request is accepted only once the
// closing word has been loaded, with the sequencer stepping through the
// 64-bit deadline adder and compare.
// The result word sits in an output register; if rsp_ready is held low the
// sequencer waits before its next push with that word on the port, and the next word is
// loaded in the cycle the current one is taken.
// Reset returns the pacer to focused, running, time zero, with the first
// deadline at 16666666 ns and an empty event budget count.

module retrace_pacer_with_focus_pause_top import rpfp_pkg::*; #(
   parameter int unsigned EVENT_BUDGET = DEFAULT_EVENT_BUDGET
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [TIME_W-1:0]  req_now_time,
   input  logic               req_focus_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_event_kind,
   output logic [TIME_W-1:0]  rsp_event_time,
   output logic               rsp_has_frame,
   output logic [COUNT_W-1:0] rsp_frame_number,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   cmd_type cmd;
   sts_type sts;

   rpfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rpfp_datapath #(
      .EVENT_BUDGET (EVENT_BUDGET)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_type),
      .req_now_time     (req_now_time),
      .req_focus_value  (req_focus_value),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_time   (rsp_event_time),
      .rsp_has_frame    (rsp_has_frame),
      .rsp_frame_number (rsp_frame_number),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule

// ----- rtl/rpfp_checker.sv -----
`timescale 1ns / 1ps

module rpfp_checker import rpfp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [2:0]        rsp_event_kind,
   input logic [TIME_W-1:0] rsp_event_time,
   input logic [1:0]        rsp_status,
   input logic              rsp_last
);

   // A stalled result word stays on the port unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_event_kind) && $stable(rsp_event_time))
      else $error("stalled result word changed");

   // Only one request is in flight.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A request is open until its closing word has been shown.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("ready before request closed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_event_kind == KIND_CLOSE)))
      else $error("last flag does not match closing word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_status == STATUS_OK))
      else $error("status on an event word");

endmodule

bind retrace_pacer_with_focus_pause_top rpfp_checker u_rpfp_checker (.*);
